// ----- rtl/core/bdq_pkg.sv -----
// Shared types and constants for the bounded deque with value delete.
// No dependencies; every other file in rtl/core refers to this package by scope.
package bdq_pkg;

    // Default capacity and the most result words one read may emit
    localparam int CAPACITY_DEF = 16;
    localparam logic [4:0] MAX_READ = 5'd16;

    typedef enum logic [2:0] {
        OP_ADD_FRONT = 3'd0,
        OP_ADD_BACK  = 3'd1,
        OP_DEL_FRONT = 3'd2,
        OP_DEL_BACK  = 3'd3,
        OP_CLEAR     = 3'd4,
        OP_DEL_VALUE = 3'd5,
        OP_READ_FRONT = 3'd6,
        OP_READ_BACK = 3'd7
    } op_t;

    typedef enum logic [1:0] {
        STAT_DONE  = 2'd0,
        STAT_ENTRY = 2'd1,
        STAT_FULL  = 2'd2,
        STAT_EMPTY = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DELV,
        ST_READ
    } state_t;

    typedef struct packed {
        logic [2:0]         operation;
        logic signed [31:0] value;
        logic [4:0]         read_count;
    } cmd_t;

    typedef struct packed {
        logic signed [31:0] item_value;
        logic [1:0]         status;
        logic [4:0]         occupancy;
        logic               last;
    } result_t;

    // Per-cycle command broadcast to every cell of the ring
    typedef struct packed {
        logic shl;   // take the value of the right neighbor
        logic shr;   // take the value of the left neighbor
        logic load;  // the addressed cell takes the load value
    } cell_ctrl_t;

endpackage

// ----- rtl/core/bdq_cell.sv -----
// One storage cell of the deque ring: holds one entry, shifts or loads.
// Depends on bdq_pkg for the cell command struct.
module bdq_cell #(
    parameter int IDX_W = 4,
    parameter int INDEX = 0
) (
    input  logic                    clk,
    input  bdq_pkg::cell_ctrl_t     ctrl,
    input  logic [IDX_W-1:0]        load_idx,
    input  logic signed [31:0]      load_val,
    input  logic signed [31:0]      left_q,
    input  logic signed [31:0]      right_q,
    output logic signed [31:0]      q
);

    logic signed [31:0] value_reg;
    logic signed [31:0] value_next;

    // Load wins over a shift so an insert can ride on the same cycle
    always_comb
    begin
        if (ctrl.load && (load_idx == IDX_W'(INDEX)))
        begin
            value_next = load_val;
        end
        else if (ctrl.shl)
        begin
            value_next = right_q;
        end
        else if (ctrl.shr)
        begin
            value_next = left_q;
        end
        else
        begin
            value_next = value_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign q = value_reg;

endmodule

// ----- rtl/core/bounded_deque_with_value_delete.sv -----
// Bounded double-ended queue of signed 32-bit values, CAPACITY entries deep.
// Commands are taken when start is high and busy is low; each result word appears on
// result for exactly one cycle with done high and cannot be held off, so the receiver
// must take every word as it comes. Inserts, deletes at either end and clear never raise
// busy: the status word follows the accepting edge. So do a delete by value or a read on
// an empty queue, and a read with a count of zero. Delete by value on a non-empty queue
// keeps busy high while the ring walks once past the front cell and compacts the
// survivors; its status word follows the last scan. Reads of at least one entry keep
// busy high, whatever the count, while the ring turns once all the way around: one
// result word leaves per cycle while the requested entries pass the front (or back)
// cell, and the order is restored when the turn completes.
// Depends on bdq_pkg and bdq_cell.
module bounded_deque_with_value_delete #(
    parameter int CAPACITY = bdq_pkg::CAPACITY_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  bdq_pkg::cmd_t      cmd,
    output logic               done,
    output bdq_pkg::result_t   result
);

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > 5) ? CNT_W : 5;

    // Ring of cells; slot 0 is the front of the queue
    logic signed [31:0]   cell_q [CAPACITY];
    bdq_pkg::cell_ctrl_t  ctrl;
    logic [IDX_W-1:0]     load_idx;
    logic signed [31:0]   load_val;

    bdq_pkg::state_t      state_reg, state_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic signed [31:0]   val_reg, val_next;      // value being deleted
    logic [CNT_W-1:0]     rem_reg, rem_next;      // entries not yet scanned
    logic [CNT_W-1:0]     kept_reg, kept_next;    // survivors so far
    logic [IDX_W-1:0]     step_reg, step_next;    // rotation step of a read
    logic [CNT_W-1:0]     base_reg, base_next;    // first emitting step
    logic [CNT_W-1:0]     n_reg, n_next;          // words to emit
    logic                 back_reg, back_next;    // reading from the back
    logic                 done_reg, done_next;
    bdq_pkg::result_t     result_reg, result_next;

    logic                 accept;
    logic                 full;
    logic                 empty;
    logic                 go_delv;
    logic                 go_read;
    logic [4:0]           rc_clamp;
    logic [CMP_W-1:0]     rc_cmp, cnt_cmp, n_cmp;
    logic [CNT_W-1:0]     n_val;
    logic                 keep;
    logic [CNT_W-1:0]     wr_pos;
    logic [CNT_W-1:0]     offset;
    logic                 in_window;
    logic [4:0]           occ;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            bdq_cell #(
                .IDX_W (IDX_W),
                .INDEX (gi)
            ) u_cell (
                .clk      (clk),
                .ctrl     (ctrl),
                .load_idx (load_idx),
                .load_val (load_val),
                .left_q   (cell_q[(gi == 0) ? CAPACITY - 1 : gi - 1]),
                .right_q  (cell_q[(gi == CAPACITY - 1) ? 0 : gi + 1]),
                .q        (cell_q[gi])
            );
        end
    endgenerate

    assign busy   = (state_reg != bdq_pkg::ST_IDLE);
    assign accept = start && !busy;
    assign full   = (count_reg == CNT_W'(CAPACITY));
    assign empty  = (count_reg == '0);
    assign occ    = 5'(count_reg);

    // Clamp the read count to the word limit, then to occupancy
    assign rc_clamp = (cmd.read_count > bdq_pkg::MAX_READ) ? bdq_pkg::MAX_READ
                                                           : cmd.read_count;
    assign rc_cmp   = CMP_W'(rc_clamp);
    assign cnt_cmp  = CMP_W'(count_reg);
    assign n_cmp    = (rc_cmp > cnt_cmp) ? cnt_cmp : rc_cmp;
    assign n_val    = n_cmp[CNT_W-1:0];

    assign go_delv = accept && !empty
                     && (cmd.operation == bdq_pkg::OP_DEL_VALUE);
    assign go_read = accept && !empty && (n_val != '0)
                     && ((cmd.operation == bdq_pkg::OP_READ_FRONT)
                         || (cmd.operation == bdq_pkg::OP_READ_BACK));

    // Value delete: the front entry drops out, survivors land behind the unscanned part
    assign keep   = (cell_q[0] != val_reg);
    assign wr_pos = rem_reg + kept_reg - 1'b1;

    // Read window: words leave while the wanted entries pass the port cell
    assign offset    = CNT_W'(step_reg) - base_reg;
    assign in_window = (CNT_W'(step_reg) >= base_reg) && (offset < n_reg);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bdq_pkg::ST_IDLE:
            begin
                if (go_delv)
                begin
                    state_next = bdq_pkg::ST_DELV;
                end
                else if (go_read)
                begin
                    state_next = bdq_pkg::ST_READ;
                end
            end
            bdq_pkg::ST_DELV:
            begin
                if (rem_reg == CNT_W'(1))
                begin
                    state_next = bdq_pkg::ST_IDLE;
                end
            end
            bdq_pkg::ST_READ:
            begin
                if (step_reg == IDX_W'(CAPACITY - 1))
                begin
                    state_next = bdq_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bdq_pkg::ST_IDLE;
            end
        endcase
    end

    // Ring commands
    always_comb
    begin
        ctrl     = '0;
        load_idx = '0;
        load_val = cmd.value;
        unique case (state_reg)
            bdq_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (cmd.operation)
                        bdq_pkg::OP_ADD_FRONT:
                        begin
                            if (!full)
                            begin
                                ctrl.shr  = 1'b1;
                                ctrl.load = 1'b1;
                            end
                        end
                        bdq_pkg::OP_ADD_BACK:
                        begin
                            if (!full)
                            begin
                                ctrl.load = 1'b1;
                                load_idx  = count_reg[IDX_W-1:0];
                            end
                        end
                        bdq_pkg::OP_DEL_FRONT:
                        begin
                            if (!empty)
                            begin
                                ctrl.shl = 1'b1;
                            end
                        end
                        default:
                        begin
                            ctrl = '0;
                        end
                    endcase
                end
            end
            bdq_pkg::ST_DELV:
            begin
                ctrl.shl  = 1'b1;
                ctrl.load = keep;
                load_idx  = wr_pos[IDX_W-1:0];
                load_val  = cell_q[0];
            end
            bdq_pkg::ST_READ:
            begin
                ctrl.shl = !back_reg;
                ctrl.shr = back_reg;
            end
            default:
            begin
                ctrl = '0;
            end
        endcase
    end

    // Datapath and result word
    always_comb
    begin
        count_next  = count_reg;
        val_next    = val_reg;
        rem_next    = rem_reg;
        kept_next   = kept_reg;
        step_next   = step_reg;
        base_next   = base_reg;
        n_next      = n_reg;
        back_next   = back_reg;
        done_next   = 1'b0;
        result_next = '0;
        case (state_reg)
            bdq_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    result_next.last = 1'b1;
                    result_next.status = bdq_pkg::STAT_DONE;
                    done_next = 1'b1;
                    case (cmd.operation) inside
                        bdq_pkg::OP_ADD_FRONT, bdq_pkg::OP_ADD_BACK:
                        begin
                            if (full)
                            begin
                                result_next.status = bdq_pkg::STAT_FULL;
                            end
                            else
                            begin
                                count_next = count_reg + 1'b1;
                            end
                        end
                        bdq_pkg::OP_DEL_FRONT, bdq_pkg::OP_DEL_BACK:
                        begin
                            if (empty)
                            begin
                                result_next.status = bdq_pkg::STAT_EMPTY;
                            end
                            else
                            begin
                                count_next = count_reg - 1'b1;
                            end
                        end
                        bdq_pkg::OP_CLEAR:
                        begin
                            count_next = '0;
                        end
                        default:
                        begin
                            // delete value and reads
                            if (empty)
                            begin
                                result_next.status = bdq_pkg::STAT_EMPTY;
                            end
                            else if (go_delv || go_read)
                            begin
                                done_next = 1'b0;
                                result_next = '0;
                            end
                        end
                    endcase
                    result_next.occupancy = 5'(count_next);
                    // Seed the multi-cycle walks
                    val_next  = cmd.value;
                    rem_next  = count_reg;
                    kept_next = '0;
                    step_next = '0;
                    n_next    = n_val;
                    back_next = (cmd.operation == bdq_pkg::OP_READ_BACK);
                    base_next = (cmd.operation == bdq_pkg::OP_READ_BACK)
                                ? CNT_W'(CAPACITY) - count_reg : '0;
                end
            end
            bdq_pkg::ST_DELV:
            begin
                rem_next  = rem_reg - 1'b1;
                kept_next = kept_reg + CNT_W'(keep);
                if (rem_reg == CNT_W'(1))
                begin
                    count_next            = kept_next;
                    done_next             = 1'b1;
                    result_next.status    = bdq_pkg::STAT_DONE;
                    result_next.occupancy = 5'(kept_next);
                    result_next.last      = 1'b1;
                end
            end
            bdq_pkg::ST_READ:
            begin
                step_next = step_reg + 1'b1;
                if (in_window)
                begin
                    done_next              = 1'b1;
                    result_next.item_value = back_reg ? cell_q[CAPACITY - 1] : cell_q[0];
                    result_next.status     = bdq_pkg::STAT_ENTRY;
                    result_next.occupancy  = occ;
                    result_next.last       = (offset == n_reg - 1'b1);
                end
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    // Hold control state under reset; payload needs none
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bdq_pkg::ST_IDLE;
            count_reg <= '0;
            rem_reg   <= '0;
            kept_reg  <= '0;
            step_reg  <= '0;
            base_reg  <= '0;
            n_reg     <= '0;
            back_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            rem_reg   <= rem_next;
            kept_reg  <= kept_next;
            step_reg  <= step_next;
            base_reg  <= base_next;
            n_reg     <= n_next;
            back_reg  <= back_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg    <= val_next;
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ----- tb/bounded_deque_with_value_delete_test.sv -----
// Self-checking testbench for bounded_deque_with_value_delete: directed and random commands,
// each predicted and compared word by word against the block's result stream.
// Depends on bdq_pkg and the RTL of bounded_deque_with_value_delete.
module bounded_deque_with_value_delete_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH        = bdq_pkg::CAPACITY_DEF;
    localparam int RANDOM_ITEMS = 125;
    localparam int MAX_REPORTS  = 10;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             start = 1'b0;
    bdq_pkg::cmd_t    cmd = '0;
    logic             busy;
    logic             done;
    bdq_pkg::result_t dut_result;

    // Commands waiting to go out, and result words the model says must come back
    bdq_pkg::cmd_t    cmd_backlog[$];
    bdq_pkg::result_t expected_words[$];

    // Shadow copy of the deque contents; slot 0 is the front
    logic signed [31:0] shadow_vals[DEPTH];
    int                 shadow_len = 0;

    // Values reused across random commands so that deletes by value find matches
    logic signed [31:0] value_pool[6];

    int idle_left    = 0;
    int no_idle_left = 0;
    int mismatches   = 0;

    bounded_deque_with_value_delete #(
        .CAPACITY(DEPTH)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .cmd(cmd),
        .done(done),
        .result(dut_result)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Hard stop in case the block hangs; far above the slowest legal run
    initial
    begin
        #1ms;
        $display("TEST FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Append one expected word; occupancy is the shadow length after the update
    function automatic void add_expected_word(logic signed [31:0] val,
                                              bdq_pkg::status_t stat, logic lst);
        bdq_pkg::result_t w;
        w.item_value = val;
        w.status     = stat;
        w.occupancy  = 5'(shadow_len);
        w.last       = lst;
        expected_words.push_back(w);
    endfunction

    // Apply one accepted command to the shadow deque and queue the words it produces
    function automatic void predict_deque_op(bdq_pkg::cmd_t c);
        int keep;
        int n;
        bdq_pkg::op_t op;
        op = bdq_pkg::op_t'(c.operation);
        case (op) inside
            bdq_pkg::OP_ADD_FRONT, bdq_pkg::OP_ADD_BACK:
            begin
                if (shadow_len >= DEPTH)
                begin
                    // Full: drop the value, report it
                    add_expected_word('0, bdq_pkg::STAT_FULL, 1'b1);
                end
                else
                begin
                    if (op == bdq_pkg::OP_ADD_FRONT)
                    begin
                        for (int i = shadow_len; i > 0; i--)
                            shadow_vals[i] = shadow_vals[i-1];
                        shadow_vals[0] = c.value;
                    end
                    else
                    begin
                        shadow_vals[shadow_len] = c.value;
                    end
                    shadow_len++;
                    add_expected_word('0, bdq_pkg::STAT_DONE, 1'b1);
                end
            end
            bdq_pkg::OP_DEL_FRONT, bdq_pkg::OP_DEL_BACK:
            begin
                if (shadow_len == 0)
                begin
                    add_expected_word('0, bdq_pkg::STAT_EMPTY, 1'b1);
                end
                else
                begin
                    if (op == bdq_pkg::OP_DEL_FRONT)
                        for (int i = 0; i < shadow_len - 1; i++)
                            shadow_vals[i] = shadow_vals[i+1];
                    shadow_len--;
                    add_expected_word('0, bdq_pkg::STAT_DONE, 1'b1);
                end
            end
            bdq_pkg::OP_CLEAR:
            begin
                shadow_len = 0;
                add_expected_word('0, bdq_pkg::STAT_DONE, 1'b1);
            end
            bdq_pkg::OP_DEL_VALUE:
            begin
                if (shadow_len == 0)
                begin
                    add_expected_word('0, bdq_pkg::STAT_EMPTY, 1'b1);
                end
                else
                begin
                    // Compact the survivors toward the front, keeping their order
                    keep = 0;
                    for (int i = 0; i < shadow_len; i++)
                    begin
                        if (shadow_vals[i] != c.value)
                        begin
                            shadow_vals[keep] = shadow_vals[i];
                            keep++;
                        end
                    end
                    shadow_len = keep;
                    add_expected_word('0, bdq_pkg::STAT_DONE, 1'b1);
                end
            end
            default:
            begin
                if (shadow_len == 0)
                begin
                    add_expected_word('0, bdq_pkg::STAT_EMPTY, 1'b1);
                end
                else
                begin
                    // Clamp the count to what is stored and to one full turn
                    n = int'(c.read_count);
                    if (n > shadow_len)
                        n = shadow_len;
                    if (n > int'(bdq_pkg::MAX_READ))
                        n = int'(bdq_pkg::MAX_READ);
                    if (n == 0)
                        add_expected_word('0, bdq_pkg::STAT_DONE, 1'b1);
                    for (int i = 0; i < n; i++)
                    begin
                        if (op == bdq_pkg::OP_READ_FRONT)
                            add_expected_word(shadow_vals[i], bdq_pkg::STAT_ENTRY,
                                              i == n - 1);
                        else
                            add_expected_word(shadow_vals[shadow_len-1-i],
                                              bdq_pkg::STAT_ENTRY, i == n - 1);
                    end
                end
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic void queue_cmd(bdq_pkg::op_t op, logic signed [31:0] val,
                                      logic [4:0] count);
        bdq_pkg::cmd_t c;
        c.operation  = op;
        c.value      = val;
        c.read_count = count;
        cmd_backlog.push_back(c);
    endfunction

    // Mostly pool values, sometimes any 32-bit pattern
    function automatic logic signed [31:0] pick_value();
        if ($urandom_range(0, 3) != 0)
            return value_pool[$urandom_range(0, 5)];
        return $urandom;
    endfunction

    function automatic logic [4:0] pick_count();
        if ($urandom_range(0, 4) == 0)
            return bdq_pkg::MAX_READ;
        return 5'($urandom_range(0, 16));
    endfunction

    function automatic bdq_pkg::op_t pick_add();
        return $urandom_range(0, 1) ? bdq_pkg::OP_ADD_FRONT : bdq_pkg::OP_ADD_BACK;
    endfunction

    function automatic bdq_pkg::op_t pick_read();
        return $urandom_range(0, 1) ? bdq_pkg::OP_READ_FRONT : bdq_pkg::OP_READ_BACK;
    endfunction

    // Idle cycles before the next command; now and then force a stretch with none
    function automatic int draw_gap();
        if (no_idle_left > 0)
        begin
            no_idle_left--;
            return 0;
        end
        if ($urandom_range(0, 9) == 0)
            no_idle_left = $urandom_range(5, 15);
        return $urandom_range(0, 4);
    endfunction

    // ------------------------------------------------------------------
    // Driver: present the head of the backlog, predict it at the accepting edge
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        int gap;
        if (rst_n)
        begin
            if (start && !busy)
            begin
                // Word taken: advance the model, then either chain or idle
                predict_deque_op(cmd_backlog.pop_front());
                gap = draw_gap();
                if (gap == 0 && cmd_backlog.size() > 0)
                begin
                    cmd <= cmd_backlog[0];
                end
                else
                begin
                    start     <= 1'b0;
                    idle_left = gap;
                end
            end
            else if (!start)
            begin
                if (idle_left > 0)
                begin
                    idle_left--;
                end
                else if (cmd_backlog.size() > 0)
                begin
                    cmd   <= cmd_backlog[0];
                    start <= 1'b1;
                end
            end
            // start high with busy high: hold the word
        end
    end

    // ------------------------------------------------------------------
    // Monitor: every done cycle carries one word; match it against the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        bdq_pkg::result_t want;
        if (rst_n && done)
        begin
            if (expected_words.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: unexpected word: value %0d status %0d occ %0d last %0b",
                             $realtime, dut_result.item_value, dut_result.status,
                             dut_result.occupancy, dut_result.last);
            end
            else
            begin
                want = expected_words.pop_front();
                if (dut_result.item_value !== want.item_value ||
                    dut_result.status     !== want.status     ||
                    dut_result.occupancy  !== want.occupancy  ||
                    dut_result.last       !== want.last)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display({"%0t: mismatch: expected value %0d status %0d occ %0d ",
                                  "last %0b, got value %0d status %0d occ %0d last %0b"},
                                 $realtime, want.item_value, want.status, want.occupancy,
                                 want.last, dut_result.item_value, dut_result.status,
                                 dut_result.occupancy, dut_result.last);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequence: build the backlog, reset, drain, report
    // ------------------------------------------------------------------
    initial
    begin
        int queued;
        int kind;
        int len;
        int pick;

        value_pool[0] = 32'sd0;
        value_pool[1] = -32'sd1;
        value_pool[2] = 32'sh7fff_ffff;
        value_pool[3] = 32'sh8000_0000;
        value_pool[4] = $urandom;
        value_pool[5] = $urandom;

        // Directed: every empty-queue case first
        queue_cmd(bdq_pkg::OP_READ_FRONT, 32'sd0, 5'd4);
        queue_cmd(bdq_pkg::OP_READ_BACK, 32'sd0, bdq_pkg::MAX_READ);
        queue_cmd(bdq_pkg::OP_DEL_FRONT, 32'sd0, 5'd0);
        queue_cmd(bdq_pkg::OP_DEL_BACK, 32'sd0, 5'd0);
        queue_cmd(bdq_pkg::OP_DEL_VALUE, 32'sd0, 5'd0);
        queue_cmd(bdq_pkg::OP_CLEAR, 32'sd0, 5'd0);
        // Fill with the value extremes from both ends
        queue_cmd(bdq_pkg::OP_ADD_BACK, 32'sh7fff_ffff, 5'd0);
        queue_cmd(bdq_pkg::OP_ADD_FRONT, 32'sh8000_0000, 5'd0);
        queue_cmd(bdq_pkg::OP_ADD_BACK, -32'sd1, 5'd0);
        queue_cmd(bdq_pkg::OP_ADD_FRONT, 32'sd0, 5'd0);
        queue_cmd(bdq_pkg::OP_ADD_BACK, 32'sd5, 5'd0);
        // Read longer than the queue, a short read from the back, a zero-length read
        queue_cmd(bdq_pkg::OP_READ_FRONT, 32'sd0, bdq_pkg::MAX_READ);
        queue_cmd(bdq_pkg::OP_READ_BACK, 32'sd0, 5'd3);
        queue_cmd(bdq_pkg::OP_READ_FRONT, 32'sd0, 5'd0);
        // Delete by value with and without a match, then both ends
        queue_cmd(bdq_pkg::OP_DEL_VALUE, -32'sd1, 5'd0);
        queue_cmd(bdq_pkg::OP_DEL_VALUE, 32'sd12345, 5'd0);
        queue_cmd(bdq_pkg::OP_DEL_FRONT, 32'sd0, 5'd0);
        queue_cmd(bdq_pkg::OP_DEL_BACK, 32'sd0, 5'd0);
        queue_cmd(bdq_pkg::OP_READ_BACK, 32'sd0, bdq_pkg::MAX_READ);
        queue_cmd(bdq_pkg::OP_CLEAR, 32'sd0, 5'd0);
        queue_cmd(bdq_pkg::OP_READ_FRONT, 32'sd0, 5'd1);

        // Random: open with a fill past capacity so the full case is always hit
        queued = 0;
        kind   = 0;
        while (queued < RANDOM_ITEMS)
        begin
            if (kind <= 1)
            begin
                // Fill burst: clear, insert from two short of capacity to past it, read and prune
                queue_cmd(bdq_pkg::OP_CLEAR, $urandom, pick_count());
                len = (queued == 0) ? DEPTH + 2 : $urandom_range(DEPTH - 2, DEPTH + 3);
                for (int i = 0; i < len; i++)
                    queue_cmd(pick_add(), pick_value(), pick_count());
                queue_cmd(pick_read(), $urandom, pick_count());
                queue_cmd(bdq_pkg::OP_DEL_VALUE, pick_value(), pick_count());
                queue_cmd(pick_read(), $urandom, bdq_pkg::MAX_READ);
                queued += len + 4;
            end
            else if (kind <= 7)
            begin
                // Mixed traffic leaning on inserts so the queue stays populated
                len = $urandom_range(4, 10);
                for (int i = 0; i < len; i++)
                begin
                    pick = $urandom_range(0, 99);
                    if (pick < 35)
                        queue_cmd(pick_add(), pick_value(), pick_count());
                    else if (pick < 50)
                        queue_cmd($urandom_range(0, 1) ? bdq_pkg::OP_DEL_FRONT
                                                       : bdq_pkg::OP_DEL_BACK,
                                  $urandom, pick_count());
                    else if (pick < 65)
                        queue_cmd(bdq_pkg::OP_DEL_VALUE, pick_value(), pick_count());
                    else if (pick < 90)
                        queue_cmd(pick_read(), pick_value(), pick_count());
                    else if (pick < 94)
                        queue_cmd(bdq_pkg::OP_CLEAR, $urandom, pick_count());
                    else
                        queue_cmd(bdq_pkg::op_t'($urandom_range(0, 7)), $urandom,
                                  pick_count());
                end
                queued += len;
            end
            else
            begin
                // Noise: anything at all
                len = $urandom_range(3, 6);
                for (int i = 0; i < len; i++)
                    queue_cmd(bdq_pkg::op_t'($urandom_range(0, 7)), $urandom,
                              5'($urandom_range(0, 16)));
                queued += len;
            end
            kind = $urandom_range(0, 9);
        end

        // Hold reset, then release it away from the clock edge
        repeat (6) @(posedge clk);
        #2 rst_n = 1'b1;

        // Wait for the backlog to drain, then for every expected word
        while (cmd_backlog.size() != 0 || start)
            @(posedge clk);
        while (expected_words.size() != 0)
            @(posedge clk);
        // Give a read a full ring turn to show any stray word
        repeat (2 * DEPTH + 4) @(posedge clk);

        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
